>>> rtl/tkns_pkg.sv
// shared types and constants for the top-k nearest search block
// used by the channel interfaces, the distance unit and the top level
package tkns_pkg;

   localparam int unsigned VALUE_W = 16;
   localparam int unsigned ID_W    = 32;
   localparam int unsigned DIST_W  = 42;
   localparam int unsigned DIM_W   = 11;
   localparam int unsigned TOPK_W  = 5;
   localparam int unsigned RANK_W  = 4;
   localparam int unsigned MODE_W  = 2;
   localparam int unsigned CSR_W   = 11;
   localparam int unsigned CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_DIM  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOPK = 1'b1;

   localparam logic [DIM_W-1:0]  DIM_RESET  = 11'd128;
   localparam logic [TOPK_W-1:0] TOPK_RESET = 5'd16;

   typedef enum logic [MODE_W-1:0] {
      MODE_QUERY     = 2'd0,
      MODE_CANDIDATE = 2'd1,
      MODE_FINISH    = 2'd2,
      MODE_NONE      = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ELEM,
      ST_INS_SCAN,
      ST_INS_SHIFT,
      ST_EMIT_RD,
      ST_EMIT
   } state_type;

   // request payload
   typedef struct packed {
      logic [MODE_W-1:0]         mode;
      logic signed [VALUE_W-1:0] value;
      logic [ID_W-1:0]           candidate_id;
      logic                      last_element;
   } req_type;

   // result payload
   typedef struct packed {
      logic [ID_W-1:0]   result_id;
      logic [DIST_W-1:0] distance;
      logic [RANK_W-1:0] rank;
      logic              found;
      logic              last;
   } rsp_type;

   // one accumulate command for the distance unit
   typedef struct packed {
      logic                      valid;
      logic signed [VALUE_W-1:0] query_value;
      logic signed [VALUE_W-1:0] cand_value;
      logic                      clear;
   } acc_cmd_type;

endpackage

>>> rtl/tkns_req_if.sv
// request channel interface carrying valid, ready and the request payload
// depends on tkns_pkg
interface tkns_req_if;
   logic              valid;
   logic              ready;
   tkns_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/tkns_rsp_if.sv
// result channel interface carrying valid, ready and the result payload
// depends on tkns_pkg
interface tkns_rsp_if;
   logic              valid;
   logic              ready;
   tkns_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/topk_l2_nearest_search.sv
// Top-k nearest search by squared L2 distance over streamed candidates.
// Channels: req (mode, value, candidate_id, last_element) and rsp (result_id,
// distance, rank, found, last), both valid/ready; csr is a plain write port
// (index 0 dim, index 1 top_k).
// Query elements are written into a query ram at one per cycle while no
// result is pending. A candidate element reads the query ram, then
// accumulates, before the next request is taken. A candidate end with a
// valid length inserts into the kept table held in a second ram: take the
// sum, compare entries in turn, shift each later entry up by a read and a
// write, then write the new entry. A finish reads the table out entry by
// entry, each result held in an output register until the receiver takes
// it; a stalled receiver simply holds the block in its emit read state.
// Reset clears counters, lengths and the kept count; the rams need no
// clearing since unread entries are never reported. Configuration is
// reset to dim 128 and top_k 16.
// depends on tkns_pkg, tkns_req_if, tkns_rsp_if, tkns_ram, tkns_dist_acc
module topk_l2_nearest_search #(
   parameter int unsigned MAX_DIM = 1024,
   parameter int unsigned MAX_K   = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   tkns_req_if.sink                          req,
   tkns_rsp_if.source                        rsp,
   input  logic                              csr_write_enable,
   input  logic [tkns_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tkns_pkg::CSR_W-1:0]        csr_write_data
);
   localparam int unsigned QA_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int unsigned CNT_W = $clog2(MAX_DIM + 2);
   localparam int unsigned KA_W  = (MAX_K > 1) ? $clog2(MAX_K) : 1;
   localparam int unsigned KC_W  = $clog2(MAX_K + 1);
   localparam int unsigned ENT_W = tkns_pkg::DIST_W + tkns_pkg::ID_W;
   localparam int unsigned DIMC_W = (CNT_W > tkns_pkg::DIM_W) ? CNT_W : tkns_pkg::DIM_W;
   localparam int unsigned KCMP_W = (KC_W > tkns_pkg::TOPK_W) ? KC_W : tkns_pkg::TOPK_W;

   // configuration registers
   logic [tkns_pkg::DIM_W-1:0]  dim_ff;
   logic [tkns_pkg::TOPK_W-1:0] top_k_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff   <= tkns_pkg::DIM_RESET;
         top_k_ff <= tkns_pkg::TOPK_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            tkns_pkg::CSR_DIM:  dim_ff   <= csr_write_data[tkns_pkg::DIM_W-1:0];
            tkns_pkg::CSR_TOPK: top_k_ff <= csr_write_data[tkns_pkg::TOPK_W-1:0];
            default: ;
         endcase
      end
   end

   // effective k
   logic [KC_W-1:0] eff_k;
   always_comb begin
      if (KCMP_W'(top_k_ff) > KCMP_W'(MAX_K)) begin
         eff_k = KC_W'(MAX_K);
      end else begin
         eff_k = KC_W'(top_k_ff);
      end
   end

   // control state
   tkns_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0] elem_cnt_ff, elem_cnt_in;
   logic [CNT_W-1:0] query_len_ff, query_len_in;
   logic [KC_W-1:0]  kept_cnt_ff, kept_cnt_in;
   logic [KC_W-1:0]  pos_ff, pos_in;
   logic [KC_W-1:0]  idx_ff, idx_in;
   logic [KC_W-1:0]  n_ff, n_in;
   logic [tkns_pkg::DIST_W-1:0] ins_dist_ff, ins_dist_in;
   logic [tkns_pkg::ID_W-1:0]   ins_id_ff, ins_id_in;
   logic signed [tkns_pkg::VALUE_W-1:0] cand_val_ff, cand_val_in;
   logic cand_last_ff, cand_last_in;
   logic [tkns_pkg::ID_W-1:0] cand_id_ff, cand_id_in;
   logic shift_ph_ff, shift_ph_in;
   logic rsp_valid_ff, rsp_valid_in;
   tkns_pkg::rsp_type rsp_ff, rsp_in;

   // rams
   logic                          q_wr_en;
   logic [QA_W-1:0]               q_addr;
   logic [tkns_pkg::VALUE_W-1:0]  q_rd;
   logic                          k_wr_en;
   logic [KA_W-1:0]               k_wr_addr, k_rd_addr;
   logic [ENT_W-1:0]              k_wr_data, k_rd;

   tkns_ram #(.WIDTH(tkns_pkg::VALUE_W), .DEPTH(MAX_DIM)) u_query_ram (
      .clock  (clock),
      .wr_en  (q_wr_en),
      .wr_addr(q_addr),
      .wr_data(req.payload.value),
      .rd_addr(q_addr),
      .rd_data(q_rd)
   );

   tkns_ram #(.WIDTH(ENT_W), .DEPTH(MAX_K)) u_kept_ram (
      .clock  (clock),
      .wr_en  (k_wr_en),
      .wr_addr(k_wr_addr),
      .wr_data(k_wr_data),
      .rd_addr(k_rd_addr),
      .rd_data(k_rd)
   );

   // distance accumulator
   tkns_pkg::acc_cmd_type       acc_cmd;
   logic [tkns_pkg::DIST_W-1:0] acc_sum;

   tkns_dist_acc u_acc (
      .clock(clock),
      .reset(reset),
      .cmd  (acc_cmd),
      .sum  (acc_sum)
   );

   logic [tkns_pkg::DIST_W-1:0] rd_dist;
   logic [tkns_pkg::ID_W-1:0]   rd_id;
   logic                        accepted;
   logic                        in_range;
   logic                        len_ok;
   logic [KC_W-1:0]             cnt_cut;

   assign rd_dist  = k_rd[ENT_W-1:tkns_pkg::ID_W];
   assign rd_id    = k_rd[tkns_pkg::ID_W-1:0];
   assign accepted = req.valid && req.ready;
   assign in_range = elem_cnt_ff < CNT_W'(MAX_DIM);
   assign q_addr   = elem_cnt_ff[QA_W-1:0];

   // next state and datapath control
   always_comb begin
      state_in     = state_ff;
      elem_cnt_in  = elem_cnt_ff;
      query_len_in = query_len_ff;
      kept_cnt_in  = kept_cnt_ff;
      pos_in       = pos_ff;
      idx_in       = idx_ff;
      n_in         = n_ff;
      ins_dist_in  = ins_dist_ff;
      ins_id_in    = ins_id_ff;
      cand_val_in  = cand_val_ff;
      cand_last_in = cand_last_ff;
      cand_id_in   = cand_id_ff;
      shift_ph_in  = shift_ph_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      req.ready    = 1'b0;
      q_wr_en      = 1'b0;
      k_wr_en      = 1'b0;
      k_wr_addr    = idx_ff[KA_W-1:0];
      k_wr_data    = {ins_dist_ff, ins_id_ff};
      k_rd_addr    = idx_ff[KA_W-1:0];
      acc_cmd      = '0;
      len_ok       = 1'b0;
      cnt_cut      = (kept_cnt_ff > eff_k) ? eff_k : kept_cnt_ff;

      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         tkns_pkg::ST_IDLE: begin
            req.ready = !rsp_valid_ff;
            if (accepted) begin
               unique case (tkns_pkg::mode_type'(req.payload.mode))
                  tkns_pkg::MODE_QUERY: begin
                     q_wr_en = in_range;
                     if (req.payload.last_element) begin
                        query_len_in = (elem_cnt_ff <= CNT_W'(MAX_DIM)) ?
                                       elem_cnt_ff + 1'b1 : elem_cnt_ff;
                        elem_cnt_in  = '0;
                        acc_cmd.clear = 1'b1;
                     end else if (elem_cnt_ff <= CNT_W'(MAX_DIM)) begin
                        elem_cnt_in = elem_cnt_ff + 1'b1;
                     end
                  end
                  tkns_pkg::MODE_CANDIDATE: begin
                     cand_val_in  = req.payload.value;
                     cand_last_in = req.payload.last_element;
                     cand_id_in   = req.payload.candidate_id;
                     state_in     = tkns_pkg::ST_ELEM;
                  end
                  tkns_pkg::MODE_FINISH: begin
                     elem_cnt_in   = '0;
                     acc_cmd.clear = 1'b1;
                     n_in   = cnt_cut;
                     idx_in = '0;
                     if (cnt_cut == '0) begin
                        rsp_in       = '0;
                        rsp_in.last  = 1'b1;
                        rsp_valid_in = 1'b1;
                        kept_cnt_in  = '0;
                     end else begin
                        state_in = tkns_pkg::ST_EMIT_RD;
                     end
                  end
                  default: ;
               endcase
            end
         end

         // query value is now out of the ram: accumulate, then maybe insert
         tkns_pkg::ST_ELEM: begin
            acc_cmd.valid       = in_range;
            acc_cmd.query_value = q_rd;
            acc_cmd.cand_value  = cand_val_ff;
            elem_cnt_in = (elem_cnt_ff <= CNT_W'(MAX_DIM)) ? elem_cnt_ff + 1'b1 : elem_cnt_ff;
            state_in = tkns_pkg::ST_IDLE;
            if (cand_last_ff) begin
               len_ok = (dim_ff != '0) && (DIMC_W'(dim_ff) <= DIMC_W'(MAX_DIM)) &&
                        (DIMC_W'(elem_cnt_in) == DIMC_W'(dim_ff)) &&
                        (DIMC_W'(query_len_ff) == DIMC_W'(dim_ff));
               elem_cnt_in = '0;
               // sum is taken after this element lands, so defer clear to scan
               if (len_ok && eff_k != '0) begin
                  kept_cnt_in = cnt_cut;
                  ins_id_in   = cand_id_ff;
                  pos_in      = '0;
                  idx_in      = '0;
                  state_in    = tkns_pkg::ST_INS_SCAN;
               end else begin
                  acc_cmd.valid = 1'b0;
                  acc_cmd.clear = 1'b1;
               end
            end
         end

         // linear scan for the insertion point, one entry per cycle
         tkns_pkg::ST_INS_SCAN: begin
            if (idx_ff == '0 && !shift_ph_ff) begin
               // first cycle: capture sum, start reading entry 0
               ins_dist_in   = acc_sum;
               acc_cmd.clear = 1'b1;
               shift_ph_in   = 1'b1;
               k_rd_addr     = '0;
            end else if (idx_ff < kept_cnt_ff && !shift_ph_ff) begin
               // k_rd holds entry idx-1... handled in ph below
               k_rd_addr = idx_ff[KA_W-1:0];
            end
            if (shift_ph_ff) begin
               // wait phase: read of idx_ff issued last cycle
               shift_ph_in = 1'b0;
               if (idx_ff >= kept_cnt_ff) begin
                  // reached end
                  if (kept_cnt_ff == eff_k) begin
                     state_in = tkns_pkg::ST_IDLE;
                  end else begin
                     pos_in = kept_cnt_ff;
                     idx_in = kept_cnt_ff;
                     state_in = tkns_pkg::ST_INS_SHIFT;
                  end
               end else begin
                  // compare read entry at idx_ff (issued previous cycle)
                  shift_ph_in = 1'b1;
                  if (rd_dist <= ins_dist_ff) begin
                     idx_in    = idx_ff + 1'b1;
                     k_rd_addr = KA_W'(idx_ff + 1'b1);
                  end else begin
                     // insertion point found
                     pos_in      = idx_ff;
                     shift_ph_in = 1'b0;
                     if (kept_cnt_ff == eff_k) begin
                        idx_in = kept_cnt_ff - 1'b1;
                     end else begin
                        idx_in = kept_cnt_ff;
                     end
                     state_in = tkns_pkg::ST_INS_SHIFT;
                  end
               end
            end
         end

         // shift entries up from the end down to pos, then write the new one
         tkns_pkg::ST_INS_SHIFT: begin
            if (idx_ff == pos_ff) begin
               k_wr_en   = 1'b1;
               k_wr_addr = pos_ff[KA_W-1:0];
               k_wr_data = {ins_dist_ff, ins_id_ff};
               if (kept_cnt_ff != eff_k) begin
                  kept_cnt_in = kept_cnt_ff + 1'b1;
               end
               shift_ph_in = 1'b0;
               idx_in      = '0;
               state_in    = tkns_pkg::ST_IDLE;
            end else if (!shift_ph_ff) begin
               k_rd_addr   = KA_W'(idx_ff - 1'b1);
               shift_ph_in = 1'b1;
            end else begin
               k_wr_en     = 1'b1;
               k_wr_addr   = idx_ff[KA_W-1:0];
               k_wr_data   = k_rd;
               idx_in      = idx_ff - 1'b1;
               shift_ph_in = 1'b0;
            end
         end

         // issue read of the next entry to report
         tkns_pkg::ST_EMIT_RD: begin
            k_rd_addr = idx_ff[KA_W-1:0];
            if (!rsp_valid_ff || rsp.ready) begin
               state_in = tkns_pkg::ST_EMIT;
            end
         end

         // load the output register from the read entry
         tkns_pkg::ST_EMIT: begin
            rsp_in.result_id = rd_id;
            rsp_in.distance  = rd_dist;
            rsp_in.rank      = idx_ff[tkns_pkg::RANK_W-1:0];
            rsp_in.found     = 1'b1;
            rsp_in.last      = (idx_ff + 1'b1 == n_ff);
            rsp_valid_in     = 1'b1;
            idx_in           = idx_ff + 1'b1;
            if (idx_ff + 1'b1 == n_ff) begin
               kept_cnt_in = '0;
               idx_in      = '0;
               state_in    = tkns_pkg::ST_IDLE;
            end else begin
               state_in = tkns_pkg::ST_EMIT_RD;
            end
         end

         default: state_in = tkns_pkg::ST_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tkns_pkg::ST_IDLE;
         elem_cnt_ff  <= '0;
         query_len_ff <= '0;
         kept_cnt_ff  <= '0;
         idx_ff       <= '0;
         pos_ff       <= '0;
         n_ff         <= '0;
         shift_ph_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         elem_cnt_ff  <= elem_cnt_in;
         query_len_ff <= query_len_in;
         kept_cnt_ff  <= kept_cnt_in;
         idx_ff       <= idx_in;
         pos_ff       <= pos_in;
         n_ff         <= n_in;
         shift_ph_ff  <= shift_ph_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ins_dist_ff  <= ins_dist_in;
      ins_id_ff    <= ins_id_in;
      cand_val_ff  <= cand_val_in;
      cand_last_ff <= cand_last_in;
      cand_id_ff   <= cand_id_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_ff;

`ifndef NO_ASSERTIONS
   // kept table never grows past the table depth
   a_kept_bound: assert property (@(posedge clock) disable iff (reset)
      kept_cnt_ff <= KC_W'(MAX_K))
      else $error("kept count exceeds table depth");

   // a stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp.ready |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("result changed while stalled");

   // requests are only taken in idle
   a_req_idle: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> state_ff == tkns_pkg::ST_IDLE)
      else $error("request taken outside idle");
`endif
endmodule

>>> rtl/tkns_ram.sv
// generic single-port-write, one-read synchronous ram with registered read
// no package dependency
module tkns_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

>>> rtl/tkns_dist_acc.sv
// squared difference accumulator with saturation at the distance width
// depends on tkns_pkg
module tkns_dist_acc (
   input  logic                         clock,
   input  logic                         reset,
   input  tkns_pkg::acc_cmd_type        cmd,
   output logic [tkns_pkg::DIST_W-1:0]  sum
);
   localparam int unsigned DIFF_W = tkns_pkg::VALUE_W + 1;
   localparam int unsigned SQ_W   = 2 * tkns_pkg::VALUE_W;

   logic signed [DIFF_W-1:0]       diff;
   logic [DIFF_W-1:0]              mag;
   logic [SQ_W-1:0]                sq;
   logic [tkns_pkg::DIST_W:0]      total;
   logic [tkns_pkg::DIST_W-1:0]    sum_ff;
   logic [tkns_pkg::DIST_W-1:0]    sum_in;

   // absolute difference and square (fits in 32 bits)
   always_comb begin
      diff  = DIFF_W'(cmd.query_value) - DIFF_W'(cmd.cand_value);
      mag   = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
      sq    = SQ_W'(mag) * SQ_W'(mag);
      total = {1'b0, sum_ff} + (tkns_pkg::DIST_W + 1)'(sq);
      sum_in = sum_ff;
      if (cmd.clear) begin
         sum_in = '0;
      end else if (cmd.valid) begin
         sum_in = total[tkns_pkg::DIST_W] ? '1 : total[tkns_pkg::DIST_W-1:0];
      end
   end

   // accumulator register
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
   end

   assign sum = sum_ff;
endmodule
